// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, disabled while reset is active.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check an implication on every rising clock edge, disabled while reset is active.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/sbsm_pkg.sv
// ----------------------------------------------------------------------------
// sbsm_pkg
// Types and constants of the serial-load bank switch mapper.
// ----------------------------------------------------------------------------
package sbsm_pkg;

  localparam int unsigned WorkRamBytes = 8192;
  localparam int unsigned WramAw       = $clog2(WorkRamBytes);
  localparam int unsigned PrgBanksMax  = 16;
  localparam int unsigned PrgBanksMin  = 2;

  localparam logic [4:0]  PRG_BANKS_MAX   = 5'(PrgBanksMax);
  localparam logic [4:0]  PRG_BANKS_MIN   = 5'(PrgBanksMin);
  localparam logic [4:0]  PRG_COUNT_RESET = 5'd16;

  localparam logic [4:0]  SHIFT_RESET     = 5'h10;
  localparam logic [4:0]  CTRL_RESET      = 5'h0C;
  localparam logic [4:0]  CTRL_PRG_FIXED  = 5'h0C;

  localparam logic [15:0] WRAM_BASE = 16'h6000;
  localparam logic [15:0] ROM_BASE  = 16'h8000;

  typedef enum logic [1:0] {
    MODE_CPU_WR = 2'd0,
    MODE_CPU_RD = 2'd1,
    MODE_PPU_RD = 2'd2,
    MODE_PPU_WR = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_WRAM = 2'd1,
    TGT_PRG  = 2'd2,
    TGT_CHR  = 2'd3
  } target_e;

  // Register select from CPU address bits 14:13 on the fifth serial write
  typedef enum logic [1:0] {
    SEL_CTRL = 2'd0,
    SEL_CHR0 = 2'd1,
    SEL_CHR1 = 2'd2,
    SEL_PRG  = 2'd3
  } reg_sel_e;

  // PRG banking modes from control bits 3:2
  typedef enum logic [1:0] {
    PRG_32K_A   = 2'd0,
    PRG_32K_B   = 2'd1,
    PRG_FIX_LO  = 2'd2,
    PRG_FIX_HI  = 2'd3
  } prg_mode_e;

  typedef struct packed {
    mode_e       mode;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    target_e     target;
    logic [17:0] mapped_address;
    logic [7:0]  read_data;
    logic        write_strobe;
    logic [1:0]  mirroring;
  } out_item_t;

endpackage

// File: rtl/core/sbsm_ram.sv
// ----------------------------------------------------------------------------
// sbsm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbsm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/serial_bank_switch_mapper_core.sv
// ----------------------------------------------------------------------------
// serial_bank_switch_mapper_core
// Cartridge bank mapper with a five-write serial register load.
//
// Each input transfer is one bus access (CPU write, CPU read, PPU read or
// PPU write). CPU writes at 0x8000 and up feed the serial register; the
// fifth write commits it to control, CHR bank 0, CHR bank 1 or PRG bank.
// Every access yields exactly one output transfer with the target, the
// mapped ROM/CHR address, work RAM read data and the current mirroring.
// An access is registered in stage 1 and then in the output register before
// out_valid_o rises; a receiver stall can hold it in between. Decode
// fills the first stage (work RAM read issued here), which feeds the output
// register. Throughput is one access per cycle without stalls; the 8KB work RAM
// has one write and one read port, so a read right after a write sees it.
// While the receiver stalls, the output register holds and the first stage
// still fills, so one more access is taken before in_stall_o rises.
// Reset empties both stages, loads the serial register marker, sets PRG
// mode 3 and the bank count to 16. Work RAM contents are not cleared.
// cfg_we_i writes the PRG bank count; write it only while the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module serial_bank_switch_mapper_core import sbsm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o,
  input  logic      cfg_we_i,
  input  logic [4:0] cfg_wdata_i
);

  // Mapper state
  logic [4:0] shift_q, shift_d;
  logic [4:0] ctrl_q, ctrl_d;
  logic [4:0] chr0_q, chr0_d;
  logic [4:0] chr1_q, chr1_d;
  logic [4:0] prg_q, prg_d;
  logic [4:0] prg_count_q;

  // Pipeline
  logic        s1_valid_q, s1_valid_d;
  target_e     s1_target_q;
  logic [17:0] s1_mapped_q;
  logic        s1_ram_rd_q;
  logic        s1_strobe_q;
  logic [1:0]  s1_mirror_q;
  logic        out_valid_q;
  out_item_t   out_item_q;

  logic accept, s2_free, s1_adv;

  target_e     target;
  logic [17:0] mapped;
  logic        strobe;
  logic        ram_on, in_wram;
  logic        ram_we, ram_re;
  logic [7:0]  ram_rdata;

  logic [4:0]  count_clamped;
  logic [3:0]  last_bank;
  logic [3:0]  prg_bank;
  logic [17:0] prg_addr;
  logic [17:0] chr_addr;
  logic [4:0]  shift_next;
  logic [12:0] chr_off;

  assign s2_free    = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && s2_free;
  assign in_stall_o = s1_valid_q && !s2_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign ram_on  = !prg_q[4];
  assign in_wram = (in_item_i.address >= WRAM_BASE) && (in_item_i.address < ROM_BASE);
  assign ram_we  = accept && (in_item_i.mode == MODE_CPU_WR) && in_wram && ram_on;
  assign ram_re  = accept && (in_item_i.mode == MODE_CPU_RD) && in_wram && ram_on;

  sbsm_ram #(
    .Width (8),
    .Depth (WorkRamBytes)
  ) u_wram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_item_i.address[WramAw-1:0]),
    .wdata_i (in_item_i.write_data),
    .re_i    (ram_re),
    .raddr_i (in_item_i.address[WramAw-1:0]),
    .rdata_o (ram_rdata)
  );

  // PRG address translation
  always_comb begin
    count_clamped = prg_count_q;
    if (prg_count_q < PRG_BANKS_MIN) begin
      count_clamped = PRG_BANKS_MIN;
    end else if (prg_count_q > PRG_BANKS_MAX) begin
      count_clamped = PRG_BANKS_MAX;
    end
    last_bank = 4'(count_clamped - 5'd1);

    prg_bank = prg_q[3:0];
    prg_addr = '0;
    unique case (prg_mode_e'(ctrl_q[3:2]))
      PRG_32K_A, PRG_32K_B: begin
        prg_addr = {prg_q[3:1], in_item_i.address[14:0]};
      end
      PRG_FIX_LO: begin
        prg_bank = in_item_i.address[14] ? prg_q[3:0] : 4'd0;
        prg_addr = {prg_bank, in_item_i.address[13:0]};
      end
      PRG_FIX_HI: begin
        prg_bank = in_item_i.address[14] ? last_bank : prg_q[3:0];
        prg_addr = {prg_bank, in_item_i.address[13:0]};
      end
      default: prg_addr = '0;
    endcase
  end

  // CHR address translation; address bits above 12 are ignored
  always_comb begin
    chr_off = in_item_i.address[12:0];
    if (!ctrl_q[4]) begin
      chr_addr = {1'b0, chr0_q[4:1], chr_off};
    end else if (!chr_off[12]) begin
      chr_addr = {1'b0, chr0_q, chr_off[11:0]};
    end else begin
      chr_addr = {1'b0, chr1_q, chr_off[11:0]};
    end
  end

  // Access decode and serial register update
  always_comb begin
    shift_d = shift_q;
    ctrl_d  = ctrl_q;
    chr0_d  = chr0_q;
    chr1_d  = chr1_q;
    prg_d   = prg_q;
    target  = TGT_NONE;
    mapped  = '0;
    strobe  = 1'b0;
    shift_next = {in_item_i.write_data[0], shift_q[4:1]};

    unique case (in_item_i.mode)
      MODE_CPU_WR: begin
        if (in_item_i.address >= ROM_BASE) begin
          if (in_item_i.write_data[7]) begin
            shift_d = SHIFT_RESET;
            ctrl_d  = ctrl_q | CTRL_PRG_FIXED;
          end else if (shift_q[0]) begin
            // Marker reached bit 0: fifth write, commit
            shift_d = SHIFT_RESET;
            unique case (reg_sel_e'(in_item_i.address[14:13]))
              SEL_CTRL: ctrl_d = shift_next;
              SEL_CHR0: chr0_d = shift_next;
              SEL_CHR1: chr1_d = shift_next;
              SEL_PRG:  prg_d  = shift_next;
              default:  ctrl_d = ctrl_q;
            endcase
          end else begin
            shift_d = shift_next;
          end
        end else if (in_wram && ram_on) begin
          target = TGT_WRAM;
          mapped = 18'(in_item_i.address[WramAw-1:0]);
        end
      end
      MODE_CPU_RD: begin
        if (in_item_i.address >= ROM_BASE) begin
          target = TGT_PRG;
          mapped = prg_addr;
        end else if (in_wram && ram_on) begin
          target = TGT_WRAM;
          mapped = 18'(in_item_i.address[WramAw-1:0]);
        end
      end
      MODE_PPU_RD: begin
        target = TGT_CHR;
        mapped = chr_addr;
      end
      MODE_PPU_WR: begin
        target = TGT_CHR;
        mapped = chr_addr;
        strobe = 1'b1;
      end
      default: target = TGT_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q     <= SHIFT_RESET;
      ctrl_q      <= CTRL_RESET;
      chr0_q      <= '0;
      chr1_q      <= '0;
      prg_q       <= '0;
      prg_count_q <= PRG_COUNT_RESET;
    end else begin
      if (accept) begin
        shift_q <= shift_d;
        ctrl_q  <= ctrl_d;
        chr0_q  <= chr0_d;
        chr1_q  <= chr1_d;
        prg_q   <= prg_d;
      end
      if (cfg_we_i) begin
        prg_count_q <= cfg_wdata_i;
      end
    end
  end

  // Stage valids
  assign s1_valid_d = accept || (s1_valid_q && !s1_adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Stage payloads; RAM read data lands alongside stage 1 and holds with it
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_target_q <= target;
      s1_mapped_q <= mapped;
      s1_ram_rd_q <= ram_re;
      s1_strobe_q <= strobe;
      s1_mirror_q <= ctrl_d[1:0];
    end
    if (s1_adv) begin
      out_item_q.target         <= s1_target_q;
      out_item_q.mapped_address <= s1_mapped_q;
      out_item_q.read_data      <= s1_ram_rd_q ? ram_rdata : 8'd0;
      out_item_q.write_strobe   <= s1_strobe_q;
      out_item_q.mirroring      <= s1_mirror_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `ASSERT_IMPL(a_stall_needs_full_s1, clk_i, rst_ni, in_stall_o, s1_valid_q,
               "stall with empty stage 1")
  `ASSERT_IMPL(a_strobe_is_chr, clk_i, rst_ni, out_valid_o && out_item_o.write_strobe,
               out_item_o.target == TGT_CHR, "write strobe outside character memory")
  `ASSERT_IMPL(a_none_is_zero, clk_i, rst_ni,
               out_valid_o && (out_item_o.target == TGT_NONE),
               (out_item_o.mapped_address == 18'd0) && (out_item_o.read_data == 8'd0),
               "target none with nonzero payload")
  `ASSERT_CLK_RST(a_serial_reset, clk_i, rst_ni,
                  (accept && (in_item_i.mode == MODE_CPU_WR) && in_item_i.address[15] &&
                   in_item_i.write_data[7]) |=>
                  ((shift_q == SHIFT_RESET) && (ctrl_q[3:2] == 2'b11)),
                  "serial reset did not clear shift or force PRG mode")

endmodule
